/* rtl/fttd_pkg.sv */
// ----------------------------------------------------------------------------
// fttd_pkg
// Shared types, codes and constants of the fan tach, rpm and duty unit.
// ----------------------------------------------------------------------------
package fttd_pkg;

    // field widths
    localparam int FUNC_W   = 2;
    localparam int CHAN_W   = 2;
    localparam int TIME_W   = 32;
    localparam int WIN_W    = 16;
    localparam int REQ_W    = 8;
    localparam int DUTY_W   = 7;
    localparam int CMP_W    = 17;
    localparam int RPM_W    = 16;
    localparam int CNT_W    = 16;
    localparam int DEB_W    = 8;
    localparam int TOP_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // count * 30000 fits in 31 bits
    localparam int NUM_W    = 31;
    // duty * (pwm_top + 1) stays below 2^23
    localparam int PROD_W   = 23;

    localparam int CHANNELS_DEF = 4;

    localparam int unsigned RPM_SCALE   = 30000;
    localparam int unsigned DUTY_MAX    = 100;
    localparam int unsigned RESET_PWM_TOP    = 1439;
    localparam int unsigned RESET_DEBOUNCE   = 2;
    localparam int unsigned RESET_START_DUTY = 50;
    localparam int unsigned DUTY_RESET =
        (RESET_START_DUTY > DUTY_MAX) ? DUTY_MAX : RESET_START_DUTY;

    // divide by 100 as multiply by ceil(2^30/100), exact for products below 2^23
    localparam int RECIP_SH = 30;
    localparam int RECIP_W  = 24;
    localparam int MULR_W   = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / 64'd100 + 64'd1);

    // command queue between front and back
    localparam int Q_DEPTH = 2;

    // input function codes
    localparam logic [FUNC_W-1:0] FUNC_EDGE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WINDOW = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DUTY   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DUTY = 2'd2;

    // classified operations
    typedef logic [1:0] t_op;
    localparam t_op OP_NONE = 2'd0;
    localparam t_op OP_EDGE = 2'd1;
    localparam t_op OP_WIN  = 2'd2;
    localparam t_op OP_DUTY = 2'd3;

    typedef struct packed {
        t_op               op;
        logic              chan_ok;
        logic [CHAN_W-1:0] chan;
        logic [TIME_W-1:0] now;
        logic [WIN_W-1:0]  win;
        logic [DUTY_W-1:0] duty;
    } t_cmd;

    typedef struct packed {
        logic [DEB_W-1:0] debounce;
        logic [TOP_W-1:0] pwm_top;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [WIN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [RPM_W-1:0] quot;
    } t_div_rsp;

endpackage

/* rtl/fttd_front.sv */
// ----------------------------------------------------------------------------
// fttd_front
// Accepts input words, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
module fttd_front
    import fttd_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [CHAN_W-1:0] i_channel,
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic [WIN_W-1:0]  i_window_ms,
    input  logic [REQ_W-1:0]  i_duty_request,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  logic              i_pop
);

    localparam int Q_AW = $clog2(Q_DEPTH);
    localparam int Q_CW = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wptr;
    logic [Q_AW-1:0]  r_rptr;
    logic [Q_CW-1:0]  r_cnt;
    t_cmd             w_cmd;
    logic             w_push;

    always_comb begin
        w_cmd         = '0;
        w_cmd.chan_ok = (32'(i_channel) < 32'(CHANNELS));
        w_cmd.chan    = i_channel;
        w_cmd.now     = i_now_ms;
        w_cmd.win     = (i_window_ms == '0) ? WIN_W'(1) : i_window_ms;
        w_cmd.duty    = (i_duty_request > REQ_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX)
                                                           : i_duty_request[DUTY_W-1:0];
        priority if (i_func == FUNC_WINDOW) begin
            w_cmd.op = OP_WIN;
        end else if (w_cmd.chan_ok && i_func == FUNC_EDGE) begin
            w_cmd.op = OP_EDGE;
        end else if (w_cmd.chan_ok && i_func == FUNC_DUTY) begin
            w_cmd.op = OP_DUTY;
        end else begin
            w_cmd.op = OP_NONE;
        end
    end

    assign o_ready     = (r_cnt != Q_CW'(Q_DEPTH));
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + Q_AW'(1);
            end
            unique case ({w_push, i_pop})
                2'b10:   r_cnt <= r_cnt + Q_CW'(1);
                2'b01:   r_cnt <= r_cnt - Q_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* rtl/fttd_div.sv */
// ----------------------------------------------------------------------------
// fttd_div
// Radix-2 restoring divider, one quotient bit per cycle, 16-bit quotient.
// ----------------------------------------------------------------------------
module fttd_div
    import fttd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEP_W = $clog2(RPM_W + 1);

    // caller guarantees num < den * 2^16, so the high part starts below den
    logic [WIN_W-1:0]  r_rem;
    logic [RPM_W-1:0]  r_quo;
    logic [WIN_W-1:0]  r_den;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [WIN_W:0]    w_trial;
    logic              w_fit;

    assign w_trial = {r_rem, r_quo[RPM_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= WIN_W'(i_req.num[NUM_W-1:RPM_W]);
            r_quo <= i_req.num[RPM_W-1:0];
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= w_fit ? WIN_W'(w_trial - {1'b0, r_den}) : w_trial[WIN_W-1:0];
            r_quo <= {r_quo[RPM_W-2:0], w_fit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(RPM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

/* rtl/fttd_back.sv */
// ----------------------------------------------------------------------------
// fttd_back
// Executes queued commands on the per-channel state and registers the result.
// ----------------------------------------------------------------------------
module fttd_back
    import fttd_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    output t_div_req          o_div_req,
    input  t_div_rsp          i_div_rsp,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DUTY_W-1:0] o_duty,
    output logic [CMP_W-1:0]  o_compare,
    output logic [RPM_W-1:0]  o_rpm,
    output logic              o_led_on
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EXT_W = (IDX_W > CHAN_W) ? IDX_W : CHAN_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_WMUL  = 3'd2;
    localparam logic [2:0] ST_WDIV  = 3'd3;
    localparam logic [2:0] ST_WWAIT = 3'd4;
    localparam logic [2:0] ST_CMP1  = 3'd5;
    localparam logic [2:0] ST_CMP2  = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0]        r_state;
    t_cmd              r_cmd;
    logic [IDX_W-1:0]  r_idx;

    logic [CNT_W-1:0]  r_count [CHANNELS];
    logic [TIME_W-1:0] r_last  [CHANNELS];
    logic              r_burst [CHANNELS];
    logic [RPM_W-1:0]  r_rpm   [CHANNELS];
    logic [DUTY_W-1:0] r_duty  [CHANNELS];

    logic [NUM_W-1:0]  r_num;
    logic [PROD_W-1:0] r_prod;
    logic [CMP_W-1:0]  r_cmpv;

    logic              r_out_valid;
    logic [DUTY_W-1:0] r_out_duty;
    logic [CMP_W-1:0]  r_out_cmp;
    logic [RPM_W-1:0]  r_out_rpm;
    logic              r_out_led;

    logic [EXT_W-1:0]  w_head_ext;
    logic [EXT_W-1:0]  w_cmd_ext;
    logic [IDX_W-1:0]  w_head_idx;
    logic [IDX_W-1:0]  w_cmd_idx;
    logic [TIME_W-1:0] w_dt;
    logic              w_sat;
    logic              w_last_ch;
    logic              w_load;
    logic [TOP_W:0]    w_period;
    logic [MULR_W-1:0] w_mulr;

    assign w_head_ext = EXT_W'(i_cmd.chan);
    assign w_cmd_ext  = EXT_W'(r_cmd.chan);
    assign w_head_idx = w_head_ext[IDX_W-1:0];
    assign w_cmd_idx  = w_cmd_ext[IDX_W-1:0];

    assign w_dt      = r_cmd.now - r_last[r_idx];
    // rpm would not fit in 16 bits
    assign w_sat     = ({1'b0, r_num} >= {r_cmd.win, {RPM_W{1'b0}}});
    assign w_last_ch = (r_idx == IDX_W'(CHANNELS - 1));
    assign w_load    = (r_state == ST_OUT) && (!r_out_valid || i_ready);
    assign w_period  = {1'b0, i_cfg.pwm_top} + (TOP_W + 1)'(1);
    assign w_mulr    = MULR_W'(r_prod) * MULR_W'(RECIP);

    assign o_pop = (r_state == ST_IDLE) && i_cmd_valid;

    assign o_div_req.start = (r_state == ST_WDIV) && !w_sat;
    assign o_div_req.num   = r_num;
    assign o_div_req.den   = r_cmd.win;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WMUL) begin
            r_num <= NUM_W'(r_count[r_idx]) * NUM_W'(RPM_SCALE);
        end
        if (r_state == ST_CMP1) begin
            r_prod <= PROD_W'(PROD_W'(r_duty[r_idx]) * PROD_W'(w_period));
        end
        if (r_state == ST_CMP2) begin
            r_cmpv <= CMP_W'(w_mulr >> RECIP_SH);
        end
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (w_load) begin
            r_out_duty <= r_cmd.chan_ok ? r_duty[r_idx] : '0;
            r_out_cmp  <= r_cmd.chan_ok ? r_cmpv : '0;
            r_out_rpm  <= r_cmd.chan_ok ? r_rpm[r_idx] : '0;
            r_out_led  <= (r_duty[0] != '0) || (r_duty[1] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_count[c] <= '0;
                r_last[c]  <= '0;
                r_burst[c] <= 1'b0;
                r_rpm[c]   <= '0;
                r_duty[c]  <= DUTY_W'(DUTY_RESET);
            end
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_idx   <= (i_cmd.op == OP_WIN) ? '0 : w_head_idx;
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    unique case (r_cmd.op)
                        OP_EDGE: begin
                            r_last[r_idx] <= r_cmd.now;
                            priority if (w_dt < TIME_W'(i_cfg.debounce)) begin
                                r_burst[r_idx] <= 1'b1;
                            end else if (r_burst[r_idx]) begin
                                // first clean edge after a burst is dropped
                                r_burst[r_idx] <= 1'b0;
                            end else if (r_count[r_idx] != '1) begin
                                r_count[r_idx] <= r_count[r_idx] + CNT_W'(1);
                            end
                            r_state <= ST_CMP1;
                        end
                        OP_DUTY: begin
                            r_duty[r_idx] <= r_cmd.duty;
                            r_state       <= ST_CMP1;
                        end
                        OP_WIN: begin
                            r_state <= ST_WMUL;
                        end
                        OP_NONE: begin
                            r_state <= ST_CMP1;
                        end
                    endcase
                end
                ST_WMUL: begin
                    r_count[r_idx] <= '0;
                    r_state        <= ST_WDIV;
                end
                ST_WDIV: begin
                    if (w_sat) begin
                        r_rpm[r_idx] <= '1;
                        if (w_last_ch) begin
                            r_idx   <= w_cmd_idx;
                            r_state <= ST_CMP1;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= ST_WMUL;
                        end
                    end else begin
                        r_state <= ST_WWAIT;
                    end
                end
                ST_WWAIT: begin
                    if (i_div_rsp.done) begin
                        r_rpm[r_idx] <= i_div_rsp.quot;
                        if (w_last_ch) begin
                            r_idx   <= w_cmd_idx;
                            r_state <= ST_CMP1;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= ST_WMUL;
                        end
                    end
                end
                ST_CMP1: begin
                    r_state <= ST_CMP2;
                end
                ST_CMP2: begin
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid   = r_out_valid;
    assign o_duty    = r_out_duty;
    assign o_compare = r_out_cmp;
    assign o_rpm     = r_out_rpm;
    assign o_led_on  = r_out_led;

endmodule

/* rtl/fan_tach_rpm_and_duty.sv */
// ----------------------------------------------------------------------------
// fan_tach_rpm_and_duty
// Multi-channel fan tachometer, rpm measurement and PWM duty unit.
// ----------------------------------------------------------------------------
// One result word per input word, in order. A front stage classifies each word
// and queues it (two entries deep), so input is taken while the back end works
// or a result waits. For a tach edge, a duty set or an idle code the back end
// does the pop, one state update, two multiply stages for the PWM compare
// (duty * (pwm_top + 1) / 100, the division done as a reciprocal multiply) and
// the output load. A window end walks all channels; each channel needs one
// multiply step, one saturation check and, unless the rpm saturates, a run of
// the shared bit-serial divider. start_duty only matters at reset, where every
// channel comes up at its reset value; later writes to it are ignored.
module fan_tach_rpm_and_duty
    import fttd_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [CHAN_W-1:0]     i_channel,
    input  logic [TIME_W-1:0]     i_now_ms,
    input  logic [WIN_W-1:0]      i_window_ms,
    input  logic [REQ_W-1:0]      i_duty_request,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DUTY_W-1:0]     o_duty,
    output logic [CMP_W-1:0]      o_compare,
    output logic [RPM_W-1:0]      o_rpm,
    output logic                  o_led_on
);

    t_cfg     r_cfg;
    logic     w_cmd_valid;
    t_cmd     w_cmd;
    logic     w_pop;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce <= DEB_W'(RESET_DEBOUNCE);
            r_cfg.pwm_top  <= TOP_W'(RESET_PWM_TOP);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEBOUNCE: r_cfg.debounce <= i_cfg_wdata[DEB_W-1:0];
                CFG_PWM_TOP:  r_cfg.pwm_top  <= i_cfg_wdata[TOP_W-1:0];
                // applied only at reset
                CFG_START_DUTY: r_cfg <= r_cfg;
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    fttd_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_channel      (i_channel),
        .i_now_ms       (i_now_ms),
        .i_window_ms    (i_window_ms),
        .i_duty_request (i_duty_request),
        .o_cmd_valid    (w_cmd_valid),
        .o_cmd          (w_cmd),
        .i_pop          (w_pop)
    );

    fttd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    fttd_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_pop       (w_pop),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_duty      (o_duty),
        .o_compare   (o_compare),
        .o_rpm       (o_rpm),
        .o_led_on    (o_led_on)
    );

`ifndef SYNTH
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_cmd_valid)
        else $error("command queue popped while empty");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider restarted while busy");

    a_div_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |=> !w_div_rsp.done)
        else $error("divider done held for more than one cycle");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_duty <= DUTY_W'(DUTY_MAX)))
        else $error("reported duty above 100 percent");
`endif

endmodule
